[hdl/clfd_pkg.sv]
// clfd_pkg: shared types and constants for the content-length deframer.
// Holds the header literal, the token word passed from front to back and record codes.
// No dependencies.
package clfd_pkg;

    // default widths of the length accumulator and the byte offsets
    localparam int DEF_LENGTH_BITS   = 32;
    localparam int DEF_POSITION_BITS = 32;

    // fixed width of the result fields
    localparam int OUT_BITS = 32;

    // header literal "Content-Length: "
    localparam int LIT_LEN     = 16;
    localparam int LIT_SEL_BITS = 4;   // selects one of LIT_LEN characters
    localparam int IDX_BITS    = 5;    // pattern index, holds 0 .. LIT_LEN
    localparam int TAIL_LEN    = 4;    // CR LF CR LF

    localparam logic [7:0] LIT_TEXT [LIT_LEN] = '{
        8'h43, 8'h6F, 8'h6E, 8'h74, 8'h65, 8'h6E, 8'h74, 8'h2D,
        8'h4C, 8'h65, 8'h6E, 8'h67, 8'h74, 8'h68, 8'h3A, 8'h20
    };

    localparam logic [7:0] CHR_CR   = 8'h0D;
    localparam logic [7:0] CHR_LF   = 8'h0A;
    localparam logic [7:0] CHR_ZERO = 8'h30;
    localparam logic [7:0] CHR_NINE = 8'h39;

    // record kinds
    localparam logic [1:0] REC_COMPLETE = 2'd0;
    localparam logic [1:0] REC_PARTIAL  = 2'd1;
    localparam logic [1:0] REC_LEFTOVER = 2'd2;

    // queue between front and back
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_BITS   = 2;
    localparam int QCNT_BITS   = 3;

    // one classified input byte
    typedef struct packed {
        logic               last;
        logic [LIT_LEN-1:0] lit_hit;   // byte equals literal character i
        logic               is_digit;
        logic [3:0]         digit;
        logic               is_cr;
        logic               is_lf;
    } token_t;

endpackage

[hdl/clfd_front.sv]
// clfd_front: input side of the deframer. Accepts bytes and classifies them
// against the header literal, the digits and CR/LF. Depends on clfd_pkg.
module clfd_front (
    input  logic            s_axis_tvalid,
    output logic            s_axis_tready,
    input  logic [7:0]      s_axis_tdata,   // [7:0] data_byte
    input  logic            s_axis_tlast,   // last_of_buffer
    input  logic            q_full,
    output logic            q_push,
    output clfd_pkg::token_t q_token
);
    import clfd_pkg::*;

    logic [7:0] byte_in;

    assign byte_in       = s_axis_tdata;
    assign s_axis_tready = !q_full;
    assign q_push        = s_axis_tvalid && !q_full;

    // compare against every literal character in parallel
    always_comb
    begin
        for (int i = 0; i < LIT_LEN; i++)
        begin
            q_token.lit_hit[i] = (byte_in == LIT_TEXT[i]);
        end
        q_token.last     = s_axis_tlast;
        q_token.is_digit = (byte_in >= CHR_ZERO) && (byte_in <= CHR_NINE);
        q_token.digit    = byte_in[3:0];
        q_token.is_cr    = (byte_in == CHR_CR);
        q_token.is_lf    = (byte_in == CHR_LF);
    end

endmodule

[hdl/clfd_queue.sv]
// clfd_queue: short token queue between the front and the back of the deframer.
// Lets either side stall on its own. Depends on clfd_pkg.
module clfd_queue (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  clfd_pkg::token_t push_token,
    output logic             full,
    input  logic             pop,
    output logic             not_empty,
    output clfd_pkg::token_t head_token
);
    import clfd_pkg::*;

    token_t               mem [QUEUE_DEPTH];
    logic [QPTR_BITS-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_BITS-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QCNT_BITS-1:0] count_reg, count_next;
    logic                 do_push, do_pop;

    assign full       = (count_reg == QCNT_BITS'(QUEUE_DEPTH));
    assign not_empty  = (count_reg != '0);
    assign do_push    = push && !full;
    assign do_pop     = pop && not_empty;
    assign head_token = mem[rd_ptr_reg];

    // pointer and fill count
    always_comb
    begin
        wr_ptr_next = do_push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_pop  ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // storage, no reset needed
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem[wr_ptr_reg] <= push_token;
        end
    end

    // fill count never passes the depth
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= QCNT_BITS'(QUEUE_DEPTH))
        else $error("queue count beyond depth");

    // a pop with nothing pushed lowers the count by one
    a_count_pop: assert property (@(posedge clk) disable iff (!rst_n)
        (do_pop && !do_push) |=> (count_reg == $past(count_reg) - 1'b1))
        else $error("queue count not decremented on pop");

    // full queue with no pop keeps its count
    a_full_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (full && !pop) |=> full)
        else $error("full queue lost an entry");

endmodule

[hdl/clfd_back.sv]
// clfd_back: deframer header matcher, length decoder, payload counter; uses clfd_pkg.
// Consumes one token a cycle unless m_axis stalls; drives the registered result word.
module clfd_back #(
    parameter int LENGTH_BITS   = clfd_pkg::DEF_LENGTH_BITS,
    parameter int POSITION_BITS = clfd_pkg::DEF_POSITION_BITS
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             q_not_empty,
    input  clfd_pkg::token_t q_token,
    output logic             q_pop,
    output logic             m_axis_tvalid,
    input  logic             m_axis_tready,
    output logic [95:0]      m_axis_tdata,  // [31:0] payload_length, [63:32] position,
                                            // [95:64] byte_count
    output logic [2:0]       m_axis_tuser   // [1:0] record_kind, [2] all_ok
);
    import clfd_pkg::*;

    typedef enum logic [2:0] {
        PH_LIT,
        PH_DIG0,
        PH_DIGS,
        PH_TAIL,
        PH_PAYLOAD
    } phase_t;

    localparam logic [LENGTH_BITS-1:0] LEN_MAX = '1;

    phase_t                   phase_reg, phase_next;
    logic [IDX_BITS-1:0]      idx_reg, idx_next;
    logic [LENGTH_BITS-1:0]   acc_reg, acc_next;
    logic [LENGTH_BITS-1:0]   left_reg, left_next;
    logic [POSITION_BITS-1:0] pos_reg, pos_next;
    logic [POSITION_BITS-1:0] hdr_reg, hdr_next;
    logic [POSITION_BITS-1:0] uncons_reg, uncons_next;

    logic                     out_valid_reg;
    logic [1:0]               out_kind_reg, out_kind_next;
    logic [OUT_BITS-1:0]      out_len_reg, out_len_next;
    logic [OUT_BITS-1:0]      out_pos_reg, out_pos_next;
    logic [OUT_BITS-1:0]      out_cnt_reg, out_cnt_next;
    logic                     out_ok_reg, out_ok_next;
    logic                     emit;

    logic                     advance;
    logic [POSITION_BITS-1:0] pos_plus;
    logic                     lit_hit, tail_hit, done;
    logic [LENGTH_BITS-1:0]   acc_base;
    logic [LENGTH_BITS+3:0]   prod;
    logic [LENGTH_BITS-1:0]   got;

    // take a token whenever the result register is free or being emptied
    assign advance = !out_valid_reg || m_axis_tready;
    assign q_pop   = advance && q_not_empty;

    assign pos_plus = pos_reg + 1'b1;
    assign lit_hit  = !idx_reg[IDX_BITS-1] && q_token.lit_hit[idx_reg[LIT_SEL_BITS-1:0]];

    // expected tail character by index
    always_comb
    begin
        unique case (idx_reg)
            IDX_BITS'(1): tail_hit = q_token.is_lf;
            IDX_BITS'(2): tail_hit = q_token.is_cr;
            IDX_BITS'(3): tail_hit = q_token.is_lf;
            default:      tail_hit = 1'b0;
        endcase
    end

    // decimal accumulate: acc*10 + digit, saturating
    assign acc_base = (phase_reg == PH_DIG0) ? '0 : acc_reg;
    assign prod     = ({4'b0, acc_base} << 3) + ({4'b0, acc_base} << 1)
                    + (LENGTH_BITS+4)'(q_token.digit);

    // header and payload state update
    always_comb
    begin
        phase_next  = phase_reg;
        idx_next    = idx_reg;
        acc_next    = acc_reg;
        left_next   = left_reg;
        pos_next    = pos_reg;
        hdr_next    = hdr_reg;
        uncons_next = uncons_reg;
        done        = 1'b0;
        got         = '0;
        emit        = 1'b0;
        out_kind_next = REC_COMPLETE;
        out_len_next  = OUT_BITS'(acc_reg);
        out_pos_next  = OUT_BITS'(hdr_reg);
        out_cnt_next  = '0;
        out_ok_next   = 1'b0;

        unique case (phase_reg)
            PH_LIT:
            begin
                if (lit_hit)
                begin
                    if (idx_reg == '0)
                    begin
                        hdr_next = pos_reg;
                    end
                    if (idx_reg == IDX_BITS'(LIT_LEN - 1))
                    begin
                        phase_next = PH_DIG0;
                        idx_next   = '0;
                        acc_next   = '0;
                    end
                    else
                    begin
                        idx_next = idx_reg + 1'b1;
                    end
                end
                else
                begin
                    phase_next = PH_LIT;
                    idx_next   = q_token.lit_hit[0] ? IDX_BITS'(1) : '0;
                    if (q_token.lit_hit[0])
                    begin
                        hdr_next = pos_reg;
                    end
                end
            end
            PH_DIG0, PH_DIGS:
            begin
                if (q_token.is_digit)
                begin
                    acc_next   = (|prod[LENGTH_BITS+3:LENGTH_BITS]) ? LEN_MAX
                                                                     : prod[LENGTH_BITS-1:0];
                    phase_next = PH_DIGS;
                end
                else if (phase_reg == PH_DIGS && q_token.is_cr)
                begin
                    phase_next = PH_TAIL;
                    idx_next   = IDX_BITS'(1);
                end
                else
                begin
                    phase_next = PH_LIT;
                    idx_next   = q_token.lit_hit[0] ? IDX_BITS'(1) : '0;
                    if (q_token.lit_hit[0])
                    begin
                        hdr_next = pos_reg;
                    end
                end
            end
            PH_TAIL:
            begin
                if (tail_hit)
                begin
                    if (idx_reg == IDX_BITS'(TAIL_LEN - 1))
                    begin
                        idx_next = '0;
                        if (acc_reg == '0)
                        begin
                            done = 1'b1;
                        end
                        else
                        begin
                            left_next  = acc_reg;
                            phase_next = PH_PAYLOAD;
                        end
                    end
                    else
                    begin
                        idx_next = idx_reg + 1'b1;
                    end
                end
                else
                begin
                    phase_next = PH_LIT;
                    idx_next   = q_token.lit_hit[0] ? IDX_BITS'(1) : '0;
                    if (q_token.lit_hit[0])
                    begin
                        hdr_next = pos_reg;
                    end
                end
            end
            PH_PAYLOAD:
            begin
                left_next = left_reg - 1'b1;
                if (left_reg == LENGTH_BITS'(1))
                begin
                    done = 1'b1;
                end
            end
            default:
            begin
                phase_next = PH_LIT;
                idx_next   = q_token.lit_hit[0] ? IDX_BITS'(1) : '0;
                if (q_token.lit_hit[0])
                begin
                    hdr_next = pos_reg;
                end
            end
        endcase

        // message complete
        if (done)
        begin
            uncons_next = pos_plus;
            phase_next  = PH_LIT;
            idx_next    = '0;
            left_next   = '0;
        end

        if (!q_token.last)
        begin
            pos_next = pos_plus;
            emit     = done;
        end
        else
        begin
            // end of buffer: one record, then back to the reset state
            emit = 1'b1;
            if (done)
            begin
                out_ok_next = 1'b1;
            end
            else if (phase_next == PH_PAYLOAD)
            begin
                got           = acc_reg - left_next;
                out_kind_next = REC_PARTIAL;
                out_pos_next  = OUT_BITS'(pos_plus - POSITION_BITS'(got));
                out_cnt_next  = OUT_BITS'(left_next);
            end
            else
            begin
                out_kind_next = REC_LEFTOVER;
                out_len_next  = '0;
                out_pos_next  = OUT_BITS'(uncons_reg);
                out_cnt_next  = OUT_BITS'(pos_plus - uncons_reg);
            end
            phase_next  = PH_LIT;
            idx_next    = '0;
            acc_next    = '0;
            left_next   = '0;
            pos_next    = '0;
            hdr_next    = '0;
            uncons_next = '0;
        end
    end

    // state and result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_LIT;
            idx_reg       <= '0;
            acc_reg       <= '0;
            left_reg      <= '0;
            pos_reg       <= '0;
            hdr_reg       <= '0;
            uncons_reg    <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (q_pop)
            begin
                phase_reg  <= phase_next;
                idx_reg    <= idx_next;
                acc_reg    <= acc_next;
                left_reg   <= left_next;
                pos_reg    <= pos_next;
                hdr_reg    <= hdr_next;
                uncons_reg <= uncons_next;
            end
            if (advance)
            begin
                out_valid_reg <= q_pop && emit;
            end
        end
    end

    // result payload, no reset needed
    always_ff @(posedge clk)
    begin
        if (q_pop && emit)
        begin
            out_kind_reg <= out_kind_next;
            out_len_reg  <= out_len_next;
            out_pos_reg  <= out_pos_next;
            out_cnt_reg  <= out_cnt_next;
            out_ok_reg   <= out_ok_next;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {out_cnt_reg, out_pos_reg, out_len_reg};
    assign m_axis_tuser  = {out_ok_reg, out_kind_reg};

    // a payload in progress always has bytes outstanding
    a_payload_left: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_PAYLOAD) |-> (left_reg != '0))
        else $error("payload phase with nothing left");

    // literal index stays inside the literal
    a_lit_idx: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_LIT) |-> (idx_reg < IDX_BITS'(LIT_LEN)))
        else $error("literal index out of range");

    // tail index between the CR already seen and the final LF
    a_tail_idx: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_TAIL) |-> (idx_reg >= IDX_BITS'(1) && idx_reg < IDX_BITS'(TAIL_LEN)))
        else $error("tail index out of range");

    // a pop on the buffer's last byte always produces a record
    a_last_emits: assert property (@(posedge clk) disable iff (!rst_n)
        (q_pop && q_token.last) |=> m_axis_tvalid)
        else $error("no record on last byte");

    // all_ok only on complete records
    a_ok_complete: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tuser[2]) |-> (m_axis_tuser[1:0] == REC_COMPLETE))
        else $error("all_ok on a non-complete record");

endmodule

[hdl/content_length_deframer_core.sv]
// content_length_deframer_core: top level of the content-length deframer.
// Instantiates clfd_front, clfd_queue and clfd_back; depends on clfd_pkg.
//
// Usage:
//   s_axis carries one buffer byte per word (tdata[7:0]); tlast marks the
//   buffer's final byte. The block hunts for "Content-Length: <digits>\r\n\r\n"
//   headers, counts the payload that follows and reports on m_axis:
//   complete messages as they end, and on the last byte a complete, partial
//   or leftover record (tuser[1:0] kind, tuser[2] all_ok).
//   tdata = {byte_count, position, payload_length}, 32 bits each.
// Throughput: one byte per cycle while m_axis_tready is high, set by the
//   state update (one multiply-by-ten add) in the back end.
// Result path: an accepted byte is stored as a token in the queue; the back
//   end pops it and registers the result into the result register, which
//   drives m_axis.
// Stall: while m_axis_tready is low the result word holds; the four-word
//   token queue keeps accepting bytes until it fills, then s_axis_tready drops.
// Reset: rst_n clears the queue, the result valid and all matching state;
//   the block is ready for a new buffer when reset is released.
//   After each buffer's last byte the matcher returns to that same state.
module content_length_deframer_core #(
    parameter int LENGTH_BITS   = clfd_pkg::DEF_LENGTH_BITS,
    parameter int POSITION_BITS = clfd_pkg::DEF_POSITION_BITS
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
    input  logic        s_axis_tlast,   // last_of_buffer
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [95:0] m_axis_tdata,   // [31:0] payload_length, [63:32] position,
                                        // [95:64] byte_count
    output logic [2:0]  m_axis_tuser    // [1:0] record_kind, [2] all_ok
);
    import clfd_pkg::*;

    token_t push_token;
    token_t head_token;
    logic   q_push, q_full, q_pop, q_not_empty;

    // byte classifier
    clfd_front u_front (
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .q_full        (q_full),
        .q_push        (q_push),
        .q_token       (push_token)
    );

    // token queue
    clfd_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (q_push),
        .push_token (push_token),
        .full       (q_full),
        .pop        (q_pop),
        .not_empty  (q_not_empty),
        .head_token (head_token)
    );

    // matcher and result register
    clfd_back #(
        .LENGTH_BITS   (LENGTH_BITS),
        .POSITION_BITS (POSITION_BITS)
    ) u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .q_not_empty   (q_not_empty),
        .q_token       (head_token),
        .q_pop         (q_pop),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

endmodule
